// ===== hw/rtl/echi_pkg.sv =====
`timescale 1ns / 1ps

package echi_pkg;

  typedef enum logic [1:0] {
    OP_HOST_READ  = 2'd0,
    OP_HOST_WRITE = 2'd1,
    OP_TICK       = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  localparam logic [1:0] CFG_CMD_PORT  = 2'd0;
  localparam logic [1:0] CFG_DATA_PORT = 2'd1;
  localparam logic [1:0] CFG_DELAY     = 2'd2;

  localparam logic [7:0] EC_READ_CMD  = 8'h80;
  localparam logic [7:0] EC_WRITE_CMD = 8'h81;

  localparam int unsigned STS_IBF_BIT = 0;
  localparam int unsigned STS_OBF_BIT = 1;
  localparam int unsigned STS_CMD_BIT = 3;

  localparam logic [15:0] CMD_PORT_RST  = 16'h0066;
  localparam logic [15:0] DATA_PORT_RST = 16'h0062;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] port;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_hit;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_obuf;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_rd;
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/echi_ctrl.sv =====
`timescale 1ns / 1ps

module echi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  echi_pkg::ctrl_sts_t sts_i,
  output echi_pkg::ctrl_cmd_t cmd_o
);
  import echi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_MEMRD = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.need_rd ? ST_MEMRD : ST_IDLE;
        end
      end
      ST_MEMRD: begin
        cmd_o.load_obuf = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/echi_dp.sv =====
`timescale 1ns / 1ps

module echi_dp #(
  parameter int unsigned SPACE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  echi_pkg::in_word_t  in_i,
  output echi_pkg::out_word_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  echi_pkg::ctrl_cmd_t cmd_i,
  output echi_pkg::ctrl_sts_t sts_o
);
  import echi_pkg::*;

  localparam int unsigned AW = $clog2(SPACE_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RD_ADDR = 2'd1,
    PH_WR_ADDR = 2'd2,
    PH_WR_VAL  = 2'd3
  } phase_e;

  in_word_t    item_q;
  logic [15:0] cmd_port_q, data_port_q;
  logic [7:0]  delay_q;
  logic [7:0]  ibuf_q, ibuf_d;
  logic        ibf_q, ibf_d;
  logic        iwc_q, iwc_d;
  logic [7:0]  obuf_q;
  logic        obf_q, obf_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  dcnt_q, dcnt_d;
  out_word_t   out_q, out_d;
  logic        out_valid_q;

  logic [7:0]             mem [SPACE_DEPTH];
  logic [SPACE_DEPTH-1:0] valid_q;
  logic [7:0]             rdata_q;
  logic                   rvalid_q;
  logic                   rin_q;

  logic       is_cmd, is_data;
  logic       cons_go, cons_cmd;
  logic [7:0] cons_byte;
  logic [7:0] dcnt_dec;
  logic       need_rd;
  logic       mem_we;
  logic [7:0] rd_addr;
  logic       take;

  function automatic logic in_range(input logic [7:0] a);
    return ({1'b0, a} < 9'(SPACE_DEPTH));
  endfunction

  assign is_cmd   = (item_q.port == cmd_port_q);
  assign is_data  = !is_cmd && (item_q.port == data_port_q);
  assign dcnt_dec = (dcnt_q != 8'd0) ? 8'(dcnt_q - 8'd1) : 8'd0;
  assign take     = out_valid_q && !out_stall_i;

  always_comb begin
    ibuf_d    = ibuf_q;
    ibf_d     = ibf_q;
    iwc_d     = iwc_q;
    obf_d     = obf_q;
    phase_d   = phase_q;
    target_d  = target_q;
    dcnt_d    = dcnt_q;
    out_d     = '0;
    cons_go   = 1'b0;
    cons_cmd  = 1'b0;
    cons_byte = 8'd0;
    need_rd   = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = 8'd0;
    case (op_e'(item_q.command))
      OP_HOST_READ: begin
        if (is_cmd) begin
          out_d.port_hit               = 1'b1;
          out_d.read_data[STS_IBF_BIT] = ibf_q;
          out_d.read_data[STS_OBF_BIT] = obf_q;
          out_d.read_data[STS_CMD_BIT] = iwc_q;
        end else if (is_data) begin
          out_d.port_hit  = 1'b1;
          out_d.read_data = obuf_q;
          obf_d           = 1'b0;
        end
      end
      OP_HOST_WRITE: begin
        if (is_cmd || is_data) begin
          out_d.port_hit = 1'b1;
          ibuf_d         = item_q.write_data;
          ibf_d          = 1'b1;
          iwc_d          = is_cmd;
          dcnt_d         = delay_q;
          if (delay_q == 8'd0) begin
            cons_go   = 1'b1;
            cons_cmd  = is_cmd;
            cons_byte = item_q.write_data;
          end
        end
      end
      OP_TICK: begin
        if (ibf_q) begin
          dcnt_d = dcnt_dec;
          if (dcnt_dec == 8'd0) begin
            cons_go   = 1'b1;
            cons_cmd  = iwc_q;
            cons_byte = ibuf_q;
          end
        end
      end
      default: begin
      end
    endcase

    if (cons_go) begin
      ibf_d = 1'b0;
      if (cons_cmd) begin
        if (cons_byte == EC_READ_CMD) begin
          phase_d = PH_RD_ADDR;
        end else if (cons_byte == EC_WRITE_CMD) begin
          phase_d = PH_WR_ADDR;
        end else begin
          phase_d = PH_IDLE;
        end
      end else begin
        case (phase_q)
          PH_RD_ADDR: begin
            need_rd = 1'b1;
            rd_addr = cons_byte;
            phase_d = PH_IDLE;
          end
          PH_WR_ADDR: begin
            target_d = cons_byte;
            phase_d  = PH_WR_VAL;
          end
          PH_WR_VAL: begin
            mem_we  = in_range(target_q);
            phase_d = PH_IDLE;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.need_rd  = need_rd;
  assign out_o          = out_q;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_port_q  <= CMD_PORT_RST;
      data_port_q <= DATA_PORT_RST;
      delay_q     <= 8'd0;
      ibuf_q      <= 8'd0;
      ibf_q       <= 1'b0;
      iwc_q       <= 1'b0;
      obuf_q      <= 8'd0;
      obf_q       <= 1'b0;
      phase_q     <= PH_IDLE;
      target_q    <= 8'd0;
      dcnt_q      <= 8'd0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CMD_PORT:  cmd_port_q  <= cfg_data_i;
          CFG_DATA_PORT: data_port_q <= cfg_data_i;
          CFG_DELAY:     delay_q     <= cfg_data_i[7:0];
          default: begin
          end
        endcase
      end
      if (take && !cmd_i.exec) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.exec) begin
        ibuf_q      <= ibuf_d;
        ibf_q       <= ibf_d;
        iwc_q       <= iwc_d;
        obf_q       <= obf_d;
        phase_q     <= phase_d;
        target_q    <= target_d;
        dcnt_q      <= dcnt_d;
        out_valid_q <= 1'b1;
        if (mem_we) begin
          valid_q[target_q[AW-1:0]] <= 1'b1;
        end
      end
      if (cmd_i.load_obuf) begin
        obuf_q <= (rin_q && rvalid_q) ? rdata_q : 8'd0;
        obf_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  // register space: one write or one registered read per item
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[target_q[AW-1:0]] <= cons_byte;
    end
    if (cmd_i.exec && need_rd) begin
      rdata_q  <= mem[rd_addr[AW-1:0]];
      rvalid_q <= valid_q[rd_addr[AW-1:0]];
      rin_q    <= in_range(rd_addr);
    end
  end

endmodule

// ===== hw/rtl/embedded_controller_host_interface.sv =====
`timescale 1ns / 1ps
// Controller side of the embedded controller command/status and data port pair, with a
// SPACE_DEPTH-byte register space cleared at reset. Each word (host read, host write or tick)
// is first captured and then executed against the buffers to produce the result word; execution
// waits while a result held by out_stall_i occupies the output. When a data byte completes a read
// command the register space is read through its registered port and the output buffer is then
// loaded in ST_MEMRD. Only one word is in flight; a new word is taken once the previous one has
// finished, even while its result still waits on the output. Configuration must be written through
// cfg_we_i/cfg_idx_i/cfg_data_i only while no word is in flight; the block does not enforce this.

module embedded_controller_host_interface #(
  parameter int unsigned SPACE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  echi_pkg::in_word_t  in_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output echi_pkg::out_word_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import echi_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  echi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  echi_dp #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while another is in flight");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.exec))
    else $error("result word without execution");

  a_obuf_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_obuf |-> $past(cmd.exec && sts.need_rd))
    else $error("output buffer load without register read");

  a_exec_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> (!out_valid_o || !out_stall_i))
    else $error("execution would overwrite a pending result");

endmodule
